// ===== rtl/mbd_pkg.sv =====
// Shared types and constants for the 2x2 box-filter mip downsampler.
// Holds the pixel transfer structs, register codes and reset values.
// No dependencies; mip_box_downsample_2x2 and the testbench use this package.
package mbd_pkg;

    // Pixel and arithmetic widths.
    localparam int CHANS    = 4;
    localparam int SAMPLE_W = 8;
    localparam int PAIR_W   = SAMPLE_W + 1;
    localparam int TOTAL_W  = SAMPLE_W + 2;

    // Default for the largest supported image side.
    localparam int MAX_SIDE_DEFAULT = 16384;

    // Configuration port geometry.
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam int SIZE_W    = 15;
    localparam int CC_W      = 3;

    // Register indexes (byte address divided by four).
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    // Register reset values.
    localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RESET  = 15'd1;
    localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RESET = 15'd1;
    localparam logic [CC_W-1:0]   CHANNEL_COUNT_RESET = 3'd4;
    localparam logic [CC_W-1:0]   CHANNEL_COUNT_MIN   = 3'd1;
    localparam logic [CC_W-1:0]   CHANNEL_COUNT_MAX   = 3'd4;

    // One source pixel.
    typedef struct packed {
        logic [SAMPLE_W-1:0] chan3_in;
        logic [SAMPLE_W-1:0] chan2_in;
        logic [SAMPLE_W-1:0] chan1_in;
        logic [SAMPLE_W-1:0] chan0_in;
    } src_pixel_t;

    // One reduced pixel.
    typedef struct packed {
        logic                level_done;
        logic [SAMPLE_W-1:0] chan3_out;
        logic [SAMPLE_W-1:0] chan2_out;
        logic [SAMPLE_W-1:0] chan1_out;
        logic [SAMPLE_W-1:0] chan0_out;
    } dst_pixel_t;

    // Four horizontal pair sums, one per channel.
    typedef logic [CHANS-1:0][PAIR_W-1:0] pair_vec_t;

endpackage

// ===== rtl/mbd_line_store.sv =====
// Single-port line store holding the pair sums of one even source row.
// Synchronous write and registered synchronous read, one access per cycle.
// Depends on nothing but its parameters.
module mbd_line_store #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 36
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mip_box_downsample_2x2.sv =====
// 2x2 box-filter mip downsampler: one raster-order source pixel per transfer in,
// one rounded 2x2 average out per completed block. A result passes the combine-stage
// and output registers before it is valid at dst. Throughput: one source pixel per
// cycle when not stalled, set by the single line-store port (one read or write each).
// Reset clears position, pending sample, pipeline valids and registers to defaults;
// the line store is not cleared, since every entry is written before it is read.
module mip_box_downsample_2x2 #(
    parameter int MAX_SIDE = mbd_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Source pixel channel.
    input  logic                          src_valid,
    output logic                          src_stall,
    input  mbd_pkg::src_pixel_t           src_pixel,
    // Reduced pixel channel.
    output logic                          dst_valid,
    input  logic                          dst_stall,
    output mbd_pkg::dst_pixel_t           dst_pixel,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbd_pkg::PADDR_W-1:0]   paddr,
    input  logic [mbd_pkg::PDATA_W-1:0]   pwdata,
    output logic [mbd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int HALF_DEPTH = (MAX_SIDE + 1) / 2;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int POS_W      = $clog2(MAX_SIDE);
    localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int DATA_W     = mbd_pkg::CHANS * mbd_pkg::PAIR_W;

    // Configuration registers.
    logic [mbd_pkg::SIZE_W-1:0]    width_reg;
    logic [mbd_pkg::SIZE_W-1:0]    height_reg;
    logic [mbd_pkg::CC_W-1:0]      cc_reg;
    logic                          cfg_wr;
    logic [mbd_pkg::REG_IDX_W-1:0] cfg_idx;
    logic                          size_wr;

    // Position and pending horizontal sample.
    logic [POS_W-1:0]                                      x_reg;
    logic [POS_W-1:0]                                      y_reg;
    logic [mbd_pkg::CHANS-1:0][mbd_pkg::SAMPLE_W-1:0]      pend_reg;

    // Front-end decode.
    logic [SIDE_W-1:0] wc;
    logic [SIDE_W-1:0] hc;
    logic              w_one;
    logic              h_one;
    logic [SIDE_W-1:0] ow;
    logic [SIDE_W-1:0] oh;
    logic              x_last;
    logic              y_last;
    logic              col_active;
    logic              row_active;
    logic              have_pair;
    logic              live;
    logic              emit;
    logic              done;
    logic [ADDR_W-1:0] idx;
    logic              accept;
    logic              mem_we;
    logic              mem_re;
    logic [mbd_pkg::CHANS-1:0][mbd_pkg::SAMPLE_W-1:0] pix;
    mbd_pkg::pair_vec_t pair;
    mbd_pkg::pair_vec_t stored;
    logic [DATA_W-1:0]  rd_data;

    // Combine stage and output register.
    logic               s1_valid_reg;
    mbd_pkg::pair_vec_t s1_pair_reg;
    logic               s1_h1_reg;
    logic               s1_done_reg;
    logic               out_free;
    logic               dst_valid_reg;
    mbd_pkg::dst_pixel_t dst_pixel_reg;
    mbd_pkg::dst_pixel_t dst_pixel_next;
    logic [mbd_pkg::CC_W-1:0] cc_eff;
    logic [mbd_pkg::CHANS-1:0][mbd_pkg::SAMPLE_W-1:0] avg;

    // Configuration write decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[mbd_pkg::PADDR_W-1:2];
    assign size_wr = cfg_wr && ((cfg_idx == mbd_pkg::REG_SOURCE_WIDTH)
                             || (cfg_idx == mbd_pkg::REG_SOURCE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbd_pkg::SOURCE_WIDTH_RESET;
            height_reg <= mbd_pkg::SOURCE_HEIGHT_RESET;
            cc_reg     <= mbd_pkg::CHANNEL_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                mbd_pkg::REG_SOURCE_WIDTH:  width_reg  <= pwdata[mbd_pkg::SIZE_W-1:0];
                mbd_pkg::REG_SOURCE_HEIGHT: height_reg <= pwdata[mbd_pkg::SIZE_W-1:0];
                mbd_pkg::REG_CHANNEL_COUNT: cc_reg     <= pwdata[mbd_pkg::CC_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (cfg_idx)
            mbd_pkg::REG_SOURCE_WIDTH:  prdata = mbd_pkg::PDATA_W'(width_reg);
            mbd_pkg::REG_SOURCE_HEIGHT: prdata = mbd_pkg::PDATA_W'(height_reg);
            mbd_pkg::REG_CHANNEL_COUNT: prdata = mbd_pkg::PDATA_W'(cc_reg);
            default:                    prdata = '0;
        endcase
    end

    // Clamp the sizes into 1..MAX_SIDE and derive the output geometry.
    always_comb
    begin
        if (width_reg == '0)
            wc = SIDE_W'(1);
        else if (width_reg > mbd_pkg::SIZE_W'(MAX_SIDE))
            wc = SIDE_W'(MAX_SIDE);
        else
            wc = SIDE_W'(width_reg);

        if (height_reg == '0)
            hc = SIDE_W'(1);
        else if (height_reg > mbd_pkg::SIZE_W'(MAX_SIDE))
            hc = SIDE_W'(MAX_SIDE);
        else
            hc = SIDE_W'(height_reg);
    end

    assign w_one  = (wc == SIDE_W'(1));
    assign h_one  = (hc == SIDE_W'(1));
    assign ow     = w_one ? SIDE_W'(1) : (wc >> 1);
    assign oh     = h_one ? SIDE_W'(1) : (hc >> 1);
    assign x_last = (SIDE_W'(x_reg) == wc - SIDE_W'(1));
    assign y_last = (SIDE_W'(y_reg) == hc - SIDE_W'(1));

    // An odd last column or row takes no part in any block.
    assign col_active = w_one || !(wc[0] && x_last);
    assign row_active = h_one || !(hc[0] && y_last);

    assign idx = ADDR_W'(x_reg >> 1);

    // Horizontal pair sums; a single-column source counts each sample twice.
    assign pix[0] = src_pixel.chan0_in;
    assign pix[1] = src_pixel.chan1_in;
    assign pix[2] = src_pixel.chan2_in;
    assign pix[3] = src_pixel.chan3_in;

    always_comb
    begin
        for (int c = 0; c < mbd_pkg::CHANS; c++)
        begin
            if (w_one)
                pair[c] = {pix[c], 1'b0};
            else
                pair[c] = {1'b0, pend_reg[c]} + {1'b0, pix[c]};
        end
    end

    assign have_pair = w_one || x_reg[0];
    assign live      = have_pair && col_active && row_active;
    assign emit      = live && (h_one || y_reg[0]);
    assign done      = (SIDE_W'(idx) == ow - SIDE_W'(1))
                    && (SIDE_W'(y_reg >> 1) == oh - SIDE_W'(1));

    // Input transfer and line-store access; even rows write, odd rows read.
    assign accept = src_valid && !src_stall;
    assign mem_we = accept && live && !h_one && !y_reg[0];
    assign mem_re = accept && live && !h_one && y_reg[0];

    mbd_line_store #(
        .DEPTH  (HALF_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .rd_en   (mem_re),
        .addr    (idx),
        .wr_data (pair),
        .rd_data (rd_data)
    );

    // Raster position and the pending even-column sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            pend_reg <= '0;
        end
        else if (size_wr)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            if (!w_one && !x_reg[0])
            begin
                pend_reg <= pix;
            end
            if (x_last)
            begin
                x_reg <= '0;
                y_reg <= y_last ? '0 : y_reg + POS_W'(1);
            end
            else
            begin
                x_reg <= x_reg + POS_W'(1);
            end
        end
    end

    // The combine stage moves on whenever the output register is free.
    assign out_free  = !dst_valid_reg || !dst_stall;
    assign src_stall = s1_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (out_free || !s1_valid_reg)
        begin
            s1_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_pair_reg <= pair;
            s1_h1_reg   <= h_one;
            s1_done_reg <= done;
        end
    end

    // Vertical sum, rounding and channel masking.
    assign stored = rd_data;
    assign cc_eff = (cc_reg < mbd_pkg::CHANNEL_COUNT_MIN) ? mbd_pkg::CHANNEL_COUNT_MIN :
                    (cc_reg > mbd_pkg::CHANNEL_COUNT_MAX) ? mbd_pkg::CHANNEL_COUNT_MAX :
                    cc_reg;

    always_comb
    begin
        logic [mbd_pkg::TOTAL_W-1:0] total;
        logic [mbd_pkg::TOTAL_W-1:0] rounded;
        for (int c = 0; c < mbd_pkg::CHANS; c++)
        begin
            if (s1_h1_reg)
                total = {s1_pair_reg[c], 1'b0};
            else
                total = {1'b0, stored[c]} + {1'b0, s1_pair_reg[c]};
            rounded = total + mbd_pkg::TOTAL_W'(2);
            if (mbd_pkg::CC_W'(c) < cc_eff)
                avg[c] = rounded[mbd_pkg::TOTAL_W-1:2];
            else
                avg[c] = '0;
        end
        dst_pixel_next.chan0_out  = avg[0];
        dst_pixel_next.chan1_out  = avg[1];
        dst_pixel_next.chan2_out  = avg[2];
        dst_pixel_next.chan3_out  = avg[3];
        dst_pixel_next.level_done = s1_done_reg;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            dst_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            dst_pixel_reg <= dst_pixel_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_pixel = dst_pixel_reg;

    // Assertions.
    // Input only stalls when both the combine stage and the output are full.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (s1_valid_reg && dst_valid_reg && dst_stall))
        else $error("source stalled without a full pipeline");

    // A pixel that completes a block always reaches the combine stage.
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> s1_valid_reg)
        else $error("completed block lost before the combine stage");

    // The raster position stays inside the clamped source size.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SIDE_W'(x_reg) < wc) && (SIDE_W'(y_reg) < hc))
        else $error("raster position outside the source size");

    // A held combine stage keeps its line-store data unchanged.
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> $stable(rd_data))
        else $error("line-store data changed under a held combine stage");

endmodule

// ===== test/tb_mip_box_downsample_2x2.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 2x2 box-filter mip downsampler.
// Predicts every reduced pixel from the accepted source stream and compares it.
// Depends on mbd_pkg and mip_box_downsample_2x2 in rtl/.
module tb_mip_box_downsample_2x2;

    import mbd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LINE_DEPTH  = (MAX_SIDE_DEFAULT + 1) / 2;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 src_valid = 1'b0;
    src_pixel_t           src_pixel = '0;
    logic                 dst_stall = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;

    // Outputs of the block.
    logic                 src_stall;
    logic                 dst_valid;
    dst_pixel_t           dst_pixel;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Source pixels waiting to be driven and reduced pixels waiting to arrive.
    src_pixel_t           pixel_queue[$];
    dst_pixel_t           expected_averages[$];
    int                   queued_count   = 0;
    int                   accepted_count = 0;
    int                   errors_seen    = 0;
    int                   cycle_count    = 0;
    logic                 src_taken      = 1'b0;
    logic                 calm;

    // Predicted block state: settings, source position, held samples, line store.
    logic [SIZE_W-1:0]    cfg_width  = SOURCE_WIDTH_RESET;
    logic [SIZE_W-1:0]    cfg_height = SOURCE_HEIGHT_RESET;
    logic [CC_W-1:0]      cfg_chans  = CHANNEL_COUNT_RESET;
    int unsigned          col_pos    = 0;
    int unsigned          row_pos    = 0;
    logic [3:0][8:0]      held_samples = '0;
    logic [3:0][9:0]      row_pairs [0:LINE_DEPTH-1];

    mip_box_downsample_2x2 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_pixel (src_pixel),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_pixel (dst_pixel),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A recurring stretch runs with no idling on either side.
    assign calm = (cycle_count % 1024) >= 880;

    // Effective image side: zero counts as one, anything above the maximum is clamped.
    function automatic int unsigned side_in_use(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_SIDE_DEFAULT)
            return MAX_SIDE_DEFAULT;
        return v;
    endfunction

    // Source pixel with the channel extremes showing up often.
    function automatic src_pixel_t random_pixel();
        logic [3:0][7:0] chan;
        int unsigned     pick;
        for (int c = 0; c < 4; c++)
        begin
            pick = $urandom_range(0, 9);
            chan[c] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
        end
        return src_pixel_t'(chan);
    endfunction

    // Advance the predicted block by one accepted source pixel.
    task automatic box_average_step(input src_pixel_t px);
        logic [3:0][7:0] sample;
        logic [3:0][8:0] pair;
        logic [3:0][9:0] total;
        logic [3:0][7:0] mean;
        int unsigned     w, h, cc, ow, oh, half_col;
        bit              have_pair, emit, done;
        sample    = px;
        w         = side_in_use(cfg_width);
        h         = side_in_use(cfg_height);
        cc        = (cfg_chans < CHANNEL_COUNT_MIN) ? CHANNEL_COUNT_MIN :
                    (cfg_chans > CHANNEL_COUNT_MAX) ? CHANNEL_COUNT_MAX : cfg_chans;
        ow        = (w == 1) ? 1 : w / 2;
        oh        = (h == 1) ? 1 : h / 2;
        half_col  = col_pos >> 1;
        have_pair = 1'b0;
        emit      = 1'b0;
        pair      = '0;
        total     = '0;

        // Horizontal pair: a one-pixel-wide source counts its sample twice.
        if (w == 1)
        begin
            for (int c = 0; c < 4; c++)
                pair[c] = {sample[c], 1'b0};
            have_pair = 1'b1;
        end
        else if (col_pos % 2 == 0)
        begin
            for (int c = 0; c < 4; c++)
                held_samples[c] = {1'b0, sample[c]};
        end
        else
        begin
            for (int c = 0; c < 4; c++)
                pair[c] = held_samples[c] + sample[c];
            have_pair = 1'b1;
        end

        // Vertical combine; an odd last column or row is dropped.
        if (have_pair && (w == 1 || col_pos < 2 * ow) && (h == 1 || row_pos < 2 * oh))
        begin
            if (h == 1)
            begin
                for (int c = 0; c < 4; c++)
                    total[c] = {pair[c], 1'b0};
                emit = 1'b1;
            end
            else if (row_pos % 2 == 0)
            begin
                for (int c = 0; c < 4; c++)
                    row_pairs[half_col][c] = {1'b0, pair[c]};
            end
            else
            begin
                for (int c = 0; c < 4; c++)
                    total[c] = row_pairs[half_col][c] + pair[c];
                emit = 1'b1;
            end
        end

        // Rounded mean; channels beyond the count in use read zero.
        if (emit)
        begin
            for (int c = 0; c < 4; c++)
                mean[c] = (c < cc) ? 8'((total[c] + 10'd2) >> 2) : 8'd0;
            done = (half_col == ow - 1) && ((row_pos >> 1) == oh - 1);
            expected_averages = {expected_averages, dst_pixel_t'({done, mean})};
        end

        // Raster position wraps into the next level after the last pixel.
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // Compare one reduced pixel with the oldest prediction.
    task automatic check_average(input dst_pixel_t got);
        dst_pixel_t      want;
        logic [3:0][7:0] want_c, got_c;
        if (expected_averages.size() == 0)
        begin
            $error("reduced pixel %h arrived with none expected", got);
            errors_seen++;
        end
        else
        begin
            want   = expected_averages.pop_front();
            want_c = want[4*SAMPLE_W-1:0];
            got_c  = got[4*SAMPLE_W-1:0];
            for (int c = 0; c < 4; c++)
            begin
                if (got_c[c] !== want_c[c])
                begin
                    $error("chan%0d_out: expected %0d, got %0d", c, want_c[c], got_c[c]);
                    errors_seen++;
                end
            end
            if (got.level_done !== want.level_done)
            begin
                $error("level_done: expected %0d, got %0d", want.level_done, got.level_done);
                errors_seen++;
            end
        end
    endtask

    // Register write over the configuration port, mirrored into the prediction.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SOURCE_WIDTH:  cfg_width  = value[SIZE_W-1:0];
            REG_SOURCE_HEIGHT: cfg_height = value[SIZE_W-1:0];
            REG_CHANNEL_COUNT: cfg_chans  = value[CC_W-1:0];
            default: ;
        endcase
        // A size write restarts the level; the channel count does not.
        if (idx == REG_SOURCE_WIDTH || idx == REG_SOURCE_HEIGHT)
        begin
            col_pos      = 0;
            row_pos      = 0;
            held_samples = '0;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_pixel(input src_pixel_t px);
        pixel_queue = {pixel_queue, px};
        queued_count++;
    endtask

    // Block until every pixel is accepted and every reduced pixel has arrived.
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_averages.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Source driver: a new transfer is offered only once the previous one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            dst_stall <= 1'b0;
        end
        else
        begin
            if (!src_valid || src_taken)
            begin
                if (pixel_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 28))
                begin
                    src_valid <= 1'b1;
                    src_pixel <= pixel_queue.pop_front();
                end
                else
                begin
                    src_valid <= 1'b0;
                    src_pixel <= $urandom();
                end
            end
            dst_stall <= !calm && ($urandom_range(0, 99) < 28);
        end
    end

    // Monitor: predict on each source transfer, check each reduced pixel transfer.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        src_taken   <= src_valid && !src_stall;
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                box_average_step(src_pixel);
                accepted_count++;
            end
            if (dst_valid && !dst_stall)
                check_average(dst_pixel);
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus: directed cases first, then random levels under random settings.
    initial
    begin : stimulus
        int unsigned w, h, kind, n;
        int          random_items;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: 1x1 source, so each pixel is its own block.
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h0000_0000);
        queue_pixel(32'h7F80_0201);
        wait_idle();

        // 3x3 source with two channels: last column and row are dropped.
        reg_write(REG_SOURCE_WIDTH, 32'd3);
        reg_write(REG_SOURCE_HEIGHT, 32'd3);
        reg_write(REG_CHANNEL_COUNT, 32'd2);
        for (int i = 0; i < 9; i++)
            queue_pixel({8'(i * 3 + 1), 8'(i), 8'(255 - i), 8'(i * 37)});
        wait_idle();

        // Zero width and zero channels act as one.
        reg_write(REG_SOURCE_WIDTH, 32'd0);
        reg_write(REG_SOURCE_HEIGHT, 32'd2);
        reg_write(REG_CHANNEL_COUNT, 32'd0);
        queue_pixel(32'hA5C3_0FF0);
        queue_pixel(32'h5A3C_F00F);
        wait_idle();

        // Channel count changed mid-level takes effect without a restart.
        reg_write(REG_SOURCE_WIDTH, 32'd2);
        reg_write(REG_SOURCE_HEIGHT, 32'd2);
        reg_write(REG_CHANNEL_COUNT, 32'd3);
        queue_pixel(32'h0102_0304);
        queue_pixel(32'hFEFD_FCFB);
        wait_idle();
        reg_write(REG_CHANNEL_COUNT, 32'hFFFF_FFFF);
        queue_pixel(32'h8081_7F7E);
        queue_pixel(32'h00FF_00FF);
        wait_idle();

        // Random phases: mostly whole small levels, some partial, some huge sides.
        random_items = 0;
        while (random_items < 400)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                reg_write(REG_CHANNEL_COUNT, $urandom());
                n = $urandom_range(1, 24);
            end
            else
            begin
                w = $urandom_range(0, 9);
                h = $urandom_range(0, 9);
                if (kind >= 93)
                begin
                    w = $urandom_range(0, 1) ? MAX_SIDE_DEFAULT
                                             : $urandom_range(MAX_SIDE_DEFAULT + 1, 32767);
                    h = $urandom_range(1, 2);
                end
                else if (kind >= 86)
                begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(0, 1) ? MAX_SIDE_DEFAULT
                                             : $urandom_range(MAX_SIDE_DEFAULT + 1, 32767);
                end
                reg_write(REG_SOURCE_WIDTH, ($urandom() & 32'hFFFF_8000) | 32'(w));
                reg_write(REG_SOURCE_HEIGHT, ($urandom() & 32'hFFFF_8000) | 32'(h));
                if ($urandom_range(0, 2) != 0)
                    reg_write(REG_CHANNEL_COUNT, $urandom());
                if (kind >= 86)
                    n = $urandom_range(20, 48);
                else
                begin
                    n = side_in_use(SIZE_W'(w)) * side_in_use(SIZE_W'(h))
                        * $urandom_range(1, 2);
                    if ($urandom_range(0, 3) == 0)
                        n = $urandom_range(1, n);
                end
            end
            repeat (n) queue_pixel(random_pixel());
            random_items += n;
            wait_idle();
        end

        if (errors_seen == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== mip_box_downsample_2x2.f =====
rtl/mbd_pkg.sv
rtl/mbd_line_store.sv
rtl/mip_box_downsample_2x2.sv
test/tb_mip_box_downsample_2x2.sv
